FILE: src/pipe_blockage_estimator_assert.svh
// assertion macros for the pipe blockage estimator
// expects signals named clk and rst in the module that uses them
`ifndef PIPE_BLOCKAGE_ESTIMATOR_ASSERT_SVH
`define PIPE_BLOCKAGE_ESTIMATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PBE_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pipe blockage estimator: assertion failed");

// antecedent implies consequent in the next cycle
`define PBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pipe blockage estimator: assertion failed");

`endif

FILE: src/pbe_pkg.sv
// shared constants, codes and types of the pipe blockage estimator
// no dependencies
package pbe_pkg;

  localparam int WINDOW  = 8;
  localparam int RING_AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int DROP_W  = 23;
  localparam int PCT_W   = 15;
  localparam int SUM_W   = DROP_W + CNT_W;

  // serial arithmetic units
  localparam int MUL_W     = 64;
  localparam int MPL_W     = 40;
  localparam int MUL_STEPS = MPL_W;
  localparam int MCNT_W    = $clog2(MUL_STEPS + 1);
  localparam int DIV_W     = 64;
  localparam int DCNT_W    = $clog2(DIV_W + 1);

  localparam logic [PCT_W-1:0] PCT_FULL  = 15'd25600;
  localparam logic [PCT_W-1:0] BAND_MOD  = 15'd6400;
  localparam logic [PCT_W-1:0] BAND_SEV  = 15'd12800;
  localparam logic [PCT_W-1:0] BAND_CRIT = 15'd19200;

  // config register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FLOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTN_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST_BAND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_SQ     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_LIN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_OFS    = 3'd6;
  localparam int CFG_DATA_W = 24;

  localparam logic [22:0]        RST_MIN_FLOW    = 23'd128;
  localparam logic [22:0]        RST_NOISE_FLOOR = 23'd26;
  localparam logic [14:0]        RST_ATTN_THR    = 15'd12800;
  localparam logic [14:0]        RST_HYST_BAND   = 15'd1280;
  localparam logic signed [23:0] RST_COEF_SQ     = 24'sd1167;
  localparam logic signed [23:0] RST_COEF_LIN    = 24'sd76625;
  localparam logic signed [23:0] RST_COEF_OFS    = -24'sd21988;

  // status codes
  localparam logic [2:0] ST_NOFLOW   = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_TOO_LOW  = 3'd2;
  localparam logic [2:0] ST_OPTIMAL  = 3'd3;
  localparam logic [2:0] ST_MODERATE = 3'd4;
  localparam logic [2:0] ST_SEVERE   = 3'd5;
  localparam logic [2:0] ST_CRITICAL = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_CS,
    S_CL,
    S_DSUM,
    S_DDIV,
    S_PMUL,
    S_PDIV,
    S_PSUM,
    S_PMEAN,
    S_DONE
  } state_t;

endpackage

FILE: src/pbe_if.sv
// sample and result channel interfaces of the pipe blockage estimator
// no dependencies
interface pbe_sample_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] inlet_pressure;
  logic signed [23:0] outlet_pressure;
  logic signed [23:0] flow_rate;

  modport source(output valid, output inlet_pressure, output outlet_pressure,
                 output flow_rate, input ready);
  modport sink(input valid, input inlet_pressure, input outlet_pressure,
               input flow_rate, output ready);
endinterface

interface pbe_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status_code;
  logic [14:0] blockage_percent;
  logic [22:0] smoothed_pressure;
  logic        requires_attention;

  modport source(output valid, output status_code, output blockage_percent,
                 output smoothed_pressure, output requires_attention, input ready);
  modport sink(input valid, input status_code, input blockage_percent,
               input smoothed_pressure, input requires_attention, output ready);
endinterface

FILE: src/pbe_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on pbe_pkg
module pbe_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [pbe_pkg::MUL_W-1:0]  mcand,
  input  logic [pbe_pkg::MPL_W-1:0]         mplier,
  output logic                              done,
  output logic [pbe_pkg::MUL_W-1:0]         prod
);

  logic                        busy;
  logic [pbe_pkg::MCNT_W-1:0]  cnt;
  logic [pbe_pkg::MUL_W-1:0]   a;
  logic [pbe_pkg::MPL_W-1:0]   b;
  logic [pbe_pkg::MUL_W-1:0]   acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pbe_pkg::MCNT_W'(pbe_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a   <= mcand;
      b   <= mplier;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + (b[0] ? a : '0);
      a   <= a << 1;
      b   <= b >> 1;
    end
  end

  assign prod = acc;

endmodule

FILE: src/pbe_div.sv
// restoring serial divider, one quotient bit per cycle
// depends on pbe_pkg
module pbe_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pbe_pkg::DIV_W-1:0]   dividend,
  input  logic [pbe_pkg::DIV_W-1:0]   divisor,
  output logic                        done,
  output logic [pbe_pkg::DIV_W-1:0]   quot
);

  logic                        busy;
  logic [pbe_pkg::DCNT_W-1:0]  cnt;
  logic [pbe_pkg::DIV_W:0]     rem;
  logic [pbe_pkg::DIV_W-1:0]   q;
  logic [pbe_pkg::DIV_W-1:0]   d;
  logic [pbe_pkg::DIV_W:0]     shifted;
  logic [pbe_pkg::DIV_W:0]     diff;
  logic                        ge;

  assign shifted = {rem[pbe_pkg::DIV_W-1:0], q[pbe_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, d};
  assign ge      = shifted >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == pbe_pkg::DCNT_W'(pbe_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= dividend;
      d   <= divisor;
    end else if (busy) begin
      rem <= ge ? diff : shifted;
      q   <= {q[pbe_pkg::DIV_W-2:0], ge};
    end
  end

  assign quot = q;

endmodule

FILE: src/pipe_blockage_estimator.sv
// top level of the pipe blockage estimator: sequencer, config, history rings
// depends on pbe_pkg, pbe_if, pbe_mul, pbe_div and the assertion header
//
// usage: one pressure/flow sample in on the sample channel gives one status
// result on the result channel; both are valid/ready, a transfer happens when
// valid and ready are high at a rising edge. config registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. unknown indexes are
// dropped. a no-flow or too-low result goes to the output register without
// any arithmetic. an invalid sample runs only the percent average (a history
// sum and a divide, skipped when the percent ring is empty). a full sample
// runs three serial multiplies for the expected drop, a history sum and a
// divide for the mean drop, a multiply and a divide for the blockage ratio,
// then another sum and divide for the mean percent. one sample is in work at
// a time and the next is taken in the cycle after the result is loaded.
// reset (rst, synchronous) empties both history rings, clears the alarm and
// restores the config defaults. a result waits in an output register while
// the receiver stalls; the next sample is taken and worked on meanwhile.
`include "pipe_blockage_estimator_assert.svh"

module pipe_blockage_estimator (
  input  logic                                clk,
  input  logic                                rst,
  pbe_sample_if.sink                          sample,
  pbe_result_if.source                        result,
  input  logic                                cfg_we,
  input  logic [pbe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // config registers
  logic [22:0]        min_flow;
  logic [22:0]        noise_floor;
  logic [14:0]        attn_thr;
  logic [14:0]        hyst_band;
  logic signed [23:0] coef_sq;
  logic signed [23:0] coef_lin;
  logic signed [23:0] coef_ofs;

  pbe_pkg::state_t state, state_next;

  // history
  logic [pbe_pkg::DROP_W-1:0]  drop_ring [pbe_pkg::WINDOW];
  logic [pbe_pkg::PCT_W-1:0]   pct_ring [pbe_pkg::WINDOW];
  logic [pbe_pkg::CNT_W-1:0]   drop_count, pct_count;
  logic [pbe_pkg::RING_AW-1:0] drop_head, pct_head;
  logic                        alarm;

  // working registers
  logic [22:0]                 flow;
  logic [37:0]                 f2q8;
  logic signed [63:0]          expct;
  logic [pbe_pkg::SUM_W-1:0]   sum;
  logic [pbe_pkg::CNT_W-1:0]   idx;
  logic [22:0]                 smooth;
  logic                        invalid_path;
  logic                        launched;

  logic [2:0]  res_status;
  logic [14:0] res_pct;
  logic [22:0] res_smooth;
  logic        res_attn;

  logic        out_valid;
  logic [2:0]  out_status;
  logic [14:0] out_pct;
  logic [22:0] out_smooth;
  logic        out_attn;
  logic        out_noflow;

  // serial units
  logic                              mul_start, mul_done;
  logic signed [pbe_pkg::MUL_W-1:0]  mul_a;
  logic [pbe_pkg::MPL_W-1:0]         mul_b;
  logic [pbe_pkg::MUL_W-1:0]         mul_p;
  logic                              div_start, div_done;
  logic [pbe_pkg::DIV_W-1:0]         div_n, div_d, div_q;

  // sample classification
  logic               accept;
  logic               flow_zero, bad_sample, flow_low;
  logic signed [24:0] drop_full;
  logic               drop_keep;

  logic signed [63:0] s24;
  logic               pct_go;
  logic [14:0]        cur_pct;
  logic [14:0]        mean_q;
  logic [15:0]        upper;
  logic signed [16:0] lower;
  logic               alarm_new;
  logic [2:0]         band_status;
  logic               drop_last, pct_last;
  logic               out_load;

  pbe_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .done   (mul_done),
    .prod   (mul_p)
  );

  pbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_q)
  );

  assign accept     = sample.valid && sample.ready;
  assign flow_zero  = sample.flow_rate == 24'sd0;
  assign bad_sample = sample.inlet_pressure < 24'sd0 || sample.outlet_pressure < 24'sd0 ||
                      sample.inlet_pressure < sample.outlet_pressure ||
                      sample.flow_rate < 24'sd0;
  assign flow_low   = sample.flow_rate <= $signed({1'b0, min_flow});
  assign drop_full  = 25'(sample.inlet_pressure) - 25'(sample.outlet_pressure);
  assign drop_keep  = drop_full > $signed({2'b0, noise_floor});

  assign s24     = $signed({25'b0, smooth, 16'b0});
  assign pct_go  = (expct > 64'sd0) && (s24 > expct);
  assign cur_pct = (div_q > 64'(pbe_pkg::PCT_FULL)) ? pbe_pkg::PCT_FULL : div_q[14:0];
  assign mean_q  = div_q[14:0];

  // hysteresis limits; lower one may go negative
  assign upper = {1'b0, attn_thr} + {1'b0, hyst_band};
  assign lower = $signed({2'b0, attn_thr}) - $signed({2'b0, hyst_band});

  always_comb begin
    alarm_new = alarm;
    if (!alarm && ({1'b0, mean_q} > upper)) begin
      alarm_new = 1'b1;
    end else if (alarm && ($signed({2'b0, mean_q}) < lower)) begin
      alarm_new = 1'b0;
    end
  end

  always_comb begin
    if (mean_q < pbe_pkg::BAND_MOD) begin
      band_status = pbe_pkg::ST_OPTIMAL;
    end else if (mean_q < pbe_pkg::BAND_SEV) begin
      band_status = pbe_pkg::ST_MODERATE;
    end else if (mean_q < pbe_pkg::BAND_CRIT) begin
      band_status = pbe_pkg::ST_SEVERE;
    end else begin
      band_status = pbe_pkg::ST_CRITICAL;
    end
  end

  assign drop_last = (idx + pbe_pkg::CNT_W'(1)) == drop_count;
  assign pct_last  = (idx + pbe_pkg::CNT_W'(1)) == pct_count;
  assign out_load  = (state == pbe_pkg::S_DONE) && (!out_valid || result.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pbe_pkg::S_IDLE: begin
        if (accept) begin
          if (flow_zero) state_next = pbe_pkg::S_DONE;
          else if (bad_sample) state_next = pbe_pkg::S_PSUM;
          else if (flow_low) state_next = pbe_pkg::S_DONE;
          else state_next = pbe_pkg::S_SQ;
        end
      end
      pbe_pkg::S_SQ: if (mul_done) state_next = pbe_pkg::S_CS;
      pbe_pkg::S_CS: if (mul_done) state_next = pbe_pkg::S_CL;
      pbe_pkg::S_CL: if (mul_done) state_next = pbe_pkg::S_DSUM;
      pbe_pkg::S_DSUM: begin
        if (drop_count == '0) state_next = pbe_pkg::S_PMUL;
        else if (drop_last) state_next = pbe_pkg::S_DDIV;
      end
      pbe_pkg::S_DDIV: if (div_done) state_next = pbe_pkg::S_PMUL;
      pbe_pkg::S_PMUL: begin
        if (!pct_go) state_next = pbe_pkg::S_PSUM;
        else if (mul_done) state_next = pbe_pkg::S_PDIV;
      end
      pbe_pkg::S_PDIV: if (div_done) state_next = pbe_pkg::S_PSUM;
      pbe_pkg::S_PSUM: begin
        if (pct_count == '0) state_next = pbe_pkg::S_DONE;
        else if (pct_last) state_next = pbe_pkg::S_PMEAN;
      end
      pbe_pkg::S_PMEAN: if (div_done) state_next = pbe_pkg::S_DONE;
      pbe_pkg::S_DONE: if (out_load) state_next = pbe_pkg::S_IDLE;
      default: state_next = pbe_pkg::S_IDLE;
    endcase
  end

  // unit controls and handshake
  always_comb begin
    sample.ready = 1'b0;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_n        = '0;
    div_d        = '0;
    case (state)
      pbe_pkg::S_IDLE: sample.ready = 1'b1;
      pbe_pkg::S_SQ: begin
        mul_start = !launched;
        mul_a     = $signed({41'b0, flow});
        mul_b     = {17'b0, flow};
      end
      pbe_pkg::S_CS: begin
        mul_start = !launched;
        mul_a     = {{40{coef_sq[23]}}, coef_sq};
        mul_b     = {2'b0, f2q8};
      end
      pbe_pkg::S_CL: begin
        mul_start = !launched;
        mul_a     = {{40{coef_lin[23]}}, coef_lin};
        mul_b     = {17'b0, flow};
      end
      pbe_pkg::S_DDIV: begin
        div_start = !launched;
        div_n     = pbe_pkg::DIV_W'(sum);
        div_d     = pbe_pkg::DIV_W'(drop_count);
      end
      pbe_pkg::S_PMUL: begin
        mul_start = !launched && pct_go;
        mul_a     = s24 - expct;
        mul_b     = pbe_pkg::MPL_W'(pbe_pkg::PCT_FULL);
      end
      pbe_pkg::S_PDIV: begin
        div_start = !launched;
        div_n     = mul_p;
        div_d     = expct;
      end
      pbe_pkg::S_PMEAN: begin
        div_start = !launched;
        div_n     = pbe_pkg::DIV_W'(sum);
        div_d     = pbe_pkg::DIV_W'(pct_count);
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pbe_pkg::S_IDLE;
      launched   <= 1'b0;
      drop_count <= '0;
      drop_head  <= '0;
      pct_count  <= '0;
      pct_head   <= '0;
      alarm      <= 1'b0;
      out_valid  <= 1'b0;
      min_flow    <= pbe_pkg::RST_MIN_FLOW;
      noise_floor <= pbe_pkg::RST_NOISE_FLOOR;
      attn_thr    <= pbe_pkg::RST_ATTN_THR;
      hyst_band   <= pbe_pkg::RST_HYST_BAND;
      coef_sq     <= pbe_pkg::RST_COEF_SQ;
      coef_lin    <= pbe_pkg::RST_COEF_LIN;
      coef_ofs    <= pbe_pkg::RST_COEF_OFS;
    end else begin
      state <= state_next;
      if (mul_start || div_start) launched <= 1'b1;
      else if (mul_done || div_done) launched <= 1'b0;

      if (accept && !flow_zero && !bad_sample && !flow_low && drop_keep) begin
        drop_head <= (drop_head == pbe_pkg::RING_AW'(pbe_pkg::WINDOW - 1)) ?
                     '0 : drop_head + 1'b1;
        if (drop_count < pbe_pkg::CNT_W'(pbe_pkg::WINDOW)) drop_count <= drop_count + 1'b1;
      end

      if ((state == pbe_pkg::S_PMUL && !pct_go) ||
          (state == pbe_pkg::S_PDIV && div_done)) begin
        pct_head <= (pct_head == pbe_pkg::RING_AW'(pbe_pkg::WINDOW - 1)) ?
                    '0 : pct_head + 1'b1;
        if (pct_count < pbe_pkg::CNT_W'(pbe_pkg::WINDOW)) pct_count <= pct_count + 1'b1;
      end

      if (state == pbe_pkg::S_PMEAN && div_done && !invalid_path) alarm <= alarm_new;

      if (out_load) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          pbe_pkg::CFG_MIN_FLOW:    min_flow    <= cfg_data[22:0];
          pbe_pkg::CFG_NOISE_FLOOR: noise_floor <= cfg_data[22:0];
          pbe_pkg::CFG_ATTN_THR:    attn_thr    <= cfg_data[14:0];
          pbe_pkg::CFG_HYST_BAND:   hyst_band   <= cfg_data[14:0];
          pbe_pkg::CFG_COEF_SQ:     coef_sq     <= $signed(cfg_data);
          pbe_pkg::CFG_COEF_LIN:    coef_lin    <= $signed(cfg_data);
          pbe_pkg::CFG_COEF_OFS:    coef_ofs    <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // rings
  always_ff @(posedge clk) begin
    if (accept && !flow_zero && !bad_sample && !flow_low && drop_keep) begin
      drop_ring[drop_head] <= drop_full[22:0];
    end
    if (state == pbe_pkg::S_PMUL && !pct_go) begin
      pct_ring[pct_head] <= '0;
    end else if (state == pbe_pkg::S_PDIV && div_done) begin
      pct_ring[pct_head] <= cur_pct;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      flow         <= sample.flow_rate[22:0];
      invalid_path <= !flow_zero && bad_sample;
      res_pct      <= '0;
      res_smooth   <= '0;
      res_attn     <= 1'b0;
      res_status   <= flow_zero ? pbe_pkg::ST_NOFLOW : pbe_pkg::ST_TOO_LOW;
    end

    // start a fresh sum on entry to either summing state
    if ((state_next == pbe_pkg::S_DSUM || state_next == pbe_pkg::S_PSUM) &&
        state_next != state) begin
      sum <= '0;
      idx <= '0;
    end else if (state == pbe_pkg::S_DSUM) begin
      sum <= sum + pbe_pkg::SUM_W'(drop_ring[idx[pbe_pkg::RING_AW-1:0]]);
      idx <= idx + 1'b1;
    end else if (state == pbe_pkg::S_PSUM) begin
      sum <= sum + pbe_pkg::SUM_W'(pct_ring[idx[pbe_pkg::RING_AW-1:0]]);
      idx <= idx + 1'b1;
    end

    if (state == pbe_pkg::S_SQ && mul_done) f2q8 <= mul_p[45:8];
    if (state == pbe_pkg::S_CS && mul_done) begin
      expct <= $signed(mul_p) + $signed({{32{coef_ofs[23]}}, coef_ofs, 8'b0});
    end
    if (state == pbe_pkg::S_CL && mul_done) expct <= expct + $signed(mul_p);

    if (state == pbe_pkg::S_DSUM && drop_count == '0) smooth <= '0;
    if (state == pbe_pkg::S_DDIV && div_done) smooth <= div_q[22:0];

    if (state == pbe_pkg::S_PSUM && pct_count == '0) begin
      res_status <= pbe_pkg::ST_INVALID;
      res_pct    <= '0;
      res_smooth <= '0;
      res_attn   <= alarm;
    end
    if (state == pbe_pkg::S_PMEAN && div_done) begin
      res_pct <= mean_q;
      if (invalid_path) begin
        res_status <= pbe_pkg::ST_INVALID;
        res_smooth <= '0;
        res_attn   <= alarm;
      end else begin
        res_status <= band_status;
        res_smooth <= smooth;
        res_attn   <= alarm_new;
      end
    end

    if (out_load) begin
      out_status <= res_status;
      out_pct    <= res_pct;
      out_smooth <= res_smooth;
      out_attn   <= res_attn;
    end
  end

  assign result.valid              = out_valid;
  assign result.status_code        = out_status;
  assign result.blockage_percent   = out_pct;
  assign result.smoothed_pressure  = out_smooth;
  assign result.requires_attention = out_attn;

  assign out_noflow = out_valid && out_status == pbe_pkg::ST_NOFLOW;

  `PBE_ASSERT_IMPLIES(a_pct_range, result.valid, result.blockage_percent <= pbe_pkg::PCT_FULL)
  `PBE_ASSERT_IMPLIES(a_drop_count, 1'b1, drop_count <= pbe_pkg::CNT_W'(pbe_pkg::WINDOW))
  `PBE_ASSERT_IMPLIES(a_pct_count, 1'b1, pct_count <= pbe_pkg::CNT_W'(pbe_pkg::WINDOW))
  `PBE_ASSERT_IMPLIES(a_noflow_zero, out_noflow, {out_pct, out_smooth, out_attn} == '0)
  `PBE_ASSERT_IMPLIES(a_one_unit, mul_start, !div_start)
  `PBE_ASSERT_NEXT(a_idle_after_load, out_load, state == pbe_pkg::S_IDLE && out_valid)

endmodule
